// ----- src/wcsp_pkg.sv -----
`default_nettype none

package wcsp_pkg;

    localparam logic [31:0] EXPECTED_RATE_RESET = 32'd48000;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] FORMAT_PCM   = 16'd1;
    localparam logic [15:0] FORMAT_FLOAT = 16'd3;
    localparam logic [15:0] BITS_PCM     = 16'd16;
    localparam logic [15:0] BITS_FLOAT   = 16'd32;
    localparam logic [32:0] FMT_BODY_LEN = 33'd16;

    localparam logic [2:0] STATUS_BUSY        = 3'd0;
    localparam logic [2:0] STATUS_OK          = 3'd1;
    localparam logic [2:0] STATUS_NOT_RIFF    = 3'd2;
    localparam logic [2:0] STATUS_NOT_WAVE    = 3'd3;
    localparam logic [2:0] STATUS_UNSUPPORTED = 3'd4;
    localparam logic [2:0] STATUS_INCOMPLETE  = 3'd5;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_file;
    } in_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        payload_first;
        logic [2:0]  parse_status;
        logic [15:0] wave_format;
        logic [15:0] channel_count;
        logic [31:0] file_sample_rate;
        logic [15:0] sample_bits;
        logic        rate_mismatch;
    } out_t;

endpackage

`default_nettype wire

// ----- src/wav_chunk_stream_parser_unit.sv -----
`default_nettype none

// Channel   Ports                       Moves
// input     s_valid s_ready s_item      one file byte per transfer, end_of_file on last
// result    m_valid m_ready m_item      one result per input byte
//
// One input transfer per cycle; the result shows in m_item the cycle after
// its input transfer. The output register frees s_ready whenever it is empty
// or being taken, so a stalled result holds only the input side.
// aresetn (synchronous, active low) restores the RIFF tag phase and the
// 48000 Hz expected rate; parsing stops until reset once a status is set.

module wav_chunk_stream_parser_unit (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire wcsp_pkg::in_t s_item,
    output logic               m_valid,
    input  wire logic          m_ready,
    output wcsp_pkg::out_t     m_item,
    input  wire logic          cfg_we,
    input  wire logic [31:0]   cfg_wdata
);

    typedef enum logic [3:0] {
        PH_RIFF,
        PH_RSIZE,
        PH_WAVE,
        PH_CID,
        PH_CSIZE,
        PH_FMT,
        PH_SKIP,
        PH_DATA,
        PH_DONE
    } phase_t;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_FMT   = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;

    phase_t         phase_reg, phase_next;
    logic [32:0]    left_reg, left_next;
    logic [31:0]    shift_reg, shift_next;
    logic [1:0]     kind_reg, kind_next;
    logic [31:0]    size_reg, size_next;
    logic [15:0]    format_reg, format_next;
    logic [15:0]    chans_reg, chans_next;
    logic [31:0]    rate_reg, rate_next;
    logic [15:0]    bits_reg, bits_next;
    logic           seen_reg, seen_next;
    logic [2:0]     status_reg, status_next;
    logic [31:0]    exp_rate_reg;
    logic           m_valid_reg;
    wcsp_pkg::out_t out_reg, out_next;

    logic        accept;
    logic [32:0] left_cur;
    logic [32:0] left_dec;
    logic        last;
    logic        do_skip;
    logic        do_finish;
    logic [32:0] skip_len;
    logic [32:0] fmt_extra;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    always_comb begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        shift_next  = shift_reg;
        kind_next   = kind_reg;
        size_next   = size_reg;
        format_next = format_reg;
        chans_next  = chans_reg;
        rate_next   = rate_reg;
        bits_next   = bits_reg;
        seen_next   = seen_reg;
        status_next = status_reg;
        do_skip     = 1'b0;
        do_finish   = 1'b0;
        skip_len    = '0;
        fmt_extra   = '0;
        left_cur    = (left_reg == '0) ? 33'd4 : left_reg;
        left_dec    = left_cur - 33'd1;
        last        = (left_dec == '0);

        out_next = '0;

        if (phase_reg != PH_DONE) begin
            shift_next = {s_item.byte_in, shift_reg[31:8]};
            left_next  = left_dec;
            case (phase_reg)
                PH_RIFF: begin
                    if (last) begin
                        if (shift_next != wcsp_pkg::TAG_RIFF) begin
                            status_next = wcsp_pkg::STATUS_NOT_RIFF;
                            phase_next  = PH_DONE;
                        end else begin
                            phase_next = PH_RSIZE;
                            left_next  = 33'd4;
                        end
                    end
                end
                PH_RSIZE: begin
                    if (last) begin
                        phase_next = PH_WAVE;
                        left_next  = 33'd4;
                    end
                end
                PH_WAVE: begin
                    if (last) begin
                        if (shift_next != wcsp_pkg::TAG_WAVE) begin
                            status_next = wcsp_pkg::STATUS_NOT_WAVE;
                            phase_next  = PH_DONE;
                        end else begin
                            phase_next = PH_CID;
                            left_next  = 33'd4;
                        end
                    end
                end
                PH_CID: begin
                    if (last) begin
                        if (shift_next == wcsp_pkg::TAG_FMT) begin
                            kind_next = KIND_FMT;
                        end else if (shift_next == wcsp_pkg::TAG_DATA) begin
                            kind_next = KIND_DATA;
                        end else begin
                            kind_next = KIND_OTHER;
                        end
                        phase_next = PH_CSIZE;
                        left_next  = 33'd4;
                    end
                end
                PH_CSIZE: begin
                    if (last) begin
                        size_next = shift_next;
                        if (kind_reg == KIND_FMT) begin
                            phase_next = PH_FMT;
                            left_next  = wcsp_pkg::FMT_BODY_LEN;
                        end else if (kind_reg == KIND_DATA) begin
                            seen_next = (shift_next != '0);
                            if (shift_next == '0) begin
                                do_finish = 1'b1;
                            end else begin
                                phase_next = PH_DATA;
                                left_next  = {1'b0, shift_next};
                            end
                        end else begin
                            do_skip  = 1'b1;
                            skip_len = {1'b0, shift_next} + {32'd0, shift_next[0]};
                        end
                    end
                end
                PH_FMT: begin
                    // byte position in the 16-byte body is 16 - bytes left
                    if (left_cur == 33'd15) begin
                        format_next = shift_next[31:16];
                    end else if (left_cur == 33'd13) begin
                        chans_next = shift_next[31:16];
                    end else if (left_cur == 33'd9) begin
                        rate_next = shift_next;
                    end else if (left_cur == 33'd1) begin
                        bits_next = shift_next[31:16];
                    end
                    if (last) begin
                        if ({1'b0, size_reg} > wcsp_pkg::FMT_BODY_LEN) begin
                            fmt_extra = {1'b0, size_reg} - wcsp_pkg::FMT_BODY_LEN;
                        end
                        do_skip  = 1'b1;
                        skip_len = fmt_extra + {32'd0, size_reg[0]};
                    end
                end
                PH_DATA: begin
                    out_next.payload_valid = 1'b1;
                    out_next.payload_byte  = s_item.byte_in;
                    out_next.payload_first = (left_cur == {1'b0, size_reg});
                    if (last) begin
                        if (format_reg != '0 && seen_reg) begin
                            do_finish = 1'b1;
                        end else begin
                            do_skip  = 1'b1;
                            skip_len = {32'd0, size_reg[0]};
                        end
                    end
                end
                default: begin
                    if (last) begin
                        do_finish = 1'b1;
                    end
                end
            endcase

            if (do_skip) begin
                if (skip_len == '0) begin
                    do_finish = 1'b1;
                end else begin
                    phase_next = PH_SKIP;
                    left_next  = skip_len;
                end
            end

            if (do_finish) begin
                if (format_next != '0 && seen_next) begin
                    if (((format_next == wcsp_pkg::FORMAT_PCM &&
                          bits_next == wcsp_pkg::BITS_PCM) ||
                         (format_next == wcsp_pkg::FORMAT_FLOAT &&
                          bits_next == wcsp_pkg::BITS_FLOAT)) &&
                        chans_next != '0) begin
                        status_next = wcsp_pkg::STATUS_OK;
                    end else begin
                        status_next = wcsp_pkg::STATUS_UNSUPPORTED;
                    end
                    phase_next = PH_DONE;
                end else begin
                    phase_next = PH_CID;
                    left_next  = 33'd4;
                end
            end

            if (s_item.end_of_file && status_next == wcsp_pkg::STATUS_BUSY) begin
                status_next = wcsp_pkg::STATUS_INCOMPLETE;
                phase_next  = PH_DONE;
            end
        end

        out_next.parse_status     = status_next;
        out_next.wave_format      = format_next;
        out_next.channel_count    = chans_next;
        out_next.file_sample_rate = rate_next;
        out_next.sample_bits      = bits_next;
        out_next.rate_mismatch    = (status_next == wcsp_pkg::STATUS_OK) &&
                                    (rate_next != exp_rate_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_RIFF;
            left_reg     <= 33'd4;
            shift_reg    <= '0;
            kind_reg     <= KIND_OTHER;
            size_reg     <= '0;
            format_reg   <= '0;
            chans_reg    <= '0;
            rate_reg     <= '0;
            bits_reg     <= '0;
            seen_reg     <= 1'b0;
            status_reg   <= wcsp_pkg::STATUS_BUSY;
            exp_rate_reg <= wcsp_pkg::EXPECTED_RATE_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                exp_rate_reg <= cfg_wdata;
            end
            if (accept) begin
                phase_reg   <= phase_next;
                left_reg    <= left_next;
                shift_reg   <= shift_next;
                kind_reg    <= kind_next;
                size_reg    <= size_next;
                format_reg  <= format_next;
                chans_reg   <= chans_next;
                rate_reg    <= rate_next;
                bits_reg    <= bits_next;
                seen_reg    <= seen_next;
                status_reg  <= status_next;
                out_reg     <= out_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb_wav_chunk_stream_parser_unit.sv -----
`default_nettype none

module tb_wav_chunk_stream_parser_unit;

    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_CYCLES = 60;
    localparam int CALM_FROM   = 1000;
    localparam int CALM_TO     = 1400;
    localparam int BODY_BYTES  = 1900;

    typedef enum logic [3:0] {
        PH_RIFF_TAG, PH_RIFF_SIZE, PH_WAVE_TAG, PH_CHUNK_ID, PH_CHUNK_SIZE,
        PH_FMT_BODY, PH_SKIP, PH_DATA, PH_DONE
    } phase_e;

    typedef enum logic [1:0] {CHUNK_OTHER, CHUNK_FMT, CHUNK_DATA} chunk_e;

    logic           aclk      = 1'b0;
    logic           aresetn   = 1'b0;
    logic           s_valid   = 1'b0;
    logic           s_ready;
    wcsp_pkg::in_t  s_item    = '0;
    logic           m_valid;
    logic           m_ready   = 1'b0;
    wcsp_pkg::out_t m_item;
    logic           cfg_we    = 1'b0;
    logic [31:0]    cfg_wdata = '0;

    wcsp_pkg::in_t  file_bytes[$];
    wcsp_pkg::out_t expected_results[$];

    int accepted    = 0;
    int taken       = 0;
    int checked     = 0;
    int mismatches  = 0;
    int n_cycles    = 0;
    int hold_left   = 0;
    logic held      = 1'b0;

    // parser mirror
    phase_e      cur_phase;
    logic [32:0] bytes_to_go;
    logic [31:0] shift_word;
    chunk_e      chunk_kind;
    logic [31:0] chunk_len;
    logic [15:0] fmt_code;
    logic [15:0] chan_count;
    logic [31:0] rate_seen;
    logic [15:0] bits_seen;
    logic        have_data;
    logic [2:0]  status_now;
    logic [31:0] rate_cfg;

    wav_chunk_stream_parser_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    function automatic void finish_chunk();
        if (fmt_code != 16'd0 && have_data) begin
            if (((fmt_code == wcsp_pkg::FORMAT_PCM && bits_seen == wcsp_pkg::BITS_PCM) ||
                 (fmt_code == wcsp_pkg::FORMAT_FLOAT &&
                  bits_seen == wcsp_pkg::BITS_FLOAT)) && chan_count != 16'd0)
                status_now = wcsp_pkg::STATUS_OK;
            else
                status_now = wcsp_pkg::STATUS_UNSUPPORTED;
            cur_phase = PH_DONE;
        end else begin
            cur_phase   = PH_CHUNK_ID;
            bytes_to_go = 33'd4;
        end
    endfunction

    function automatic void skip_bytes(input logic [32:0] n);
        if (n == 33'd0) begin
            finish_chunk();
        end else begin
            cur_phase   = PH_SKIP;
            bytes_to_go = n;
        end
    endfunction

    function automatic wcsp_pkg::out_t parse_byte(input wcsp_pkg::in_t x);
        wcsp_pkg::out_t r;
        logic [32:0]    pos;
        logic [32:0]    extra;
        r = '0;
        if (cur_phase != PH_DONE) begin
            shift_word = {x.byte_in, shift_word[31:8]};
            if (bytes_to_go == 33'd0)
                bytes_to_go = 33'd4;
            pos = wcsp_pkg::FMT_BODY_LEN - bytes_to_go;
            if (cur_phase == PH_DATA) begin
                r.payload_valid = 1'b1;
                r.payload_byte  = x.byte_in;
                r.payload_first = bytes_to_go == {1'b0, chunk_len};
            end
            bytes_to_go = bytes_to_go - 33'd1;
            case (cur_phase)
                PH_RIFF_TAG: if (bytes_to_go == 33'd0) begin
                    if (shift_word != wcsp_pkg::TAG_RIFF) begin
                        status_now = wcsp_pkg::STATUS_NOT_RIFF;
                        cur_phase  = PH_DONE;
                    end else begin
                        cur_phase   = PH_RIFF_SIZE;
                        bytes_to_go = 33'd4;
                    end
                end
                PH_RIFF_SIZE: if (bytes_to_go == 33'd0) begin
                    cur_phase   = PH_WAVE_TAG;
                    bytes_to_go = 33'd4;
                end
                PH_WAVE_TAG: if (bytes_to_go == 33'd0) begin
                    if (shift_word != wcsp_pkg::TAG_WAVE) begin
                        status_now = wcsp_pkg::STATUS_NOT_WAVE;
                        cur_phase  = PH_DONE;
                    end else begin
                        cur_phase   = PH_CHUNK_ID;
                        bytes_to_go = 33'd4;
                    end
                end
                PH_CHUNK_ID: if (bytes_to_go == 33'd0) begin
                    chunk_kind  = (shift_word == wcsp_pkg::TAG_FMT) ? CHUNK_FMT :
                                  (shift_word == wcsp_pkg::TAG_DATA) ? CHUNK_DATA :
                                  CHUNK_OTHER;
                    cur_phase   = PH_CHUNK_SIZE;
                    bytes_to_go = 33'd4;
                end
                PH_CHUNK_SIZE: if (bytes_to_go == 33'd0) begin
                    chunk_len = shift_word;
                    if (chunk_kind == CHUNK_FMT) begin
                        cur_phase   = PH_FMT_BODY;
                        bytes_to_go = wcsp_pkg::FMT_BODY_LEN;
                    end else if (chunk_kind == CHUNK_DATA) begin
                        have_data = chunk_len != 32'd0;
                        if (chunk_len == 32'd0) begin
                            finish_chunk();
                        end else begin
                            cur_phase   = PH_DATA;
                            bytes_to_go = {1'b0, chunk_len};
                        end
                    end else begin
                        skip_bytes({1'b0, chunk_len} + {32'd0, chunk_len[0]});
                    end
                end
                PH_FMT_BODY: begin
                    if (pos == 33'd1)
                        fmt_code = shift_word[31:16];
                    else if (pos == 33'd3)
                        chan_count = shift_word[31:16];
                    else if (pos == 33'd7)
                        rate_seen = shift_word;
                    else if (pos == 33'd15)
                        bits_seen = shift_word[31:16];
                    if (bytes_to_go == 33'd0) begin
                        extra = (chunk_len > 32'd16) ?
                                {1'b0, chunk_len} - wcsp_pkg::FMT_BODY_LEN : 33'd0;
                        skip_bytes(extra + {32'd0, chunk_len[0]});
                    end
                end
                PH_DATA: if (bytes_to_go == 33'd0) begin
                    if (fmt_code != 16'd0 && have_data)
                        finish_chunk();
                    else
                        skip_bytes({32'd0, chunk_len[0]});
                end
                default: if (bytes_to_go == 33'd0) begin
                    finish_chunk();
                end
            endcase
            if (x.end_of_file && status_now == wcsp_pkg::STATUS_BUSY) begin
                status_now = wcsp_pkg::STATUS_INCOMPLETE;
                cur_phase  = PH_DONE;
            end
        end
        r.parse_status     = status_now;
        r.wave_format      = fmt_code;
        r.channel_count    = chan_count;
        r.file_sample_rate = rate_seen;
        r.sample_bits      = bits_seen;
        r.rate_mismatch    = status_now == wcsp_pkg::STATUS_OK && rate_seen != rate_cfg;
        return r;
    endfunction

    function automatic logic [31:0] edgy(input int w);
        logic [31:0] ones;
        ones = (w == 32) ? 32'hFFFF_FFFF : (32'd1 << w) - 32'd1;
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return ones;
            default: return $urandom & ones;
        endcase
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic eof);
        wcsp_pkg::in_t t;
        t.byte_in     = b;
        t.end_of_file = eof;
        file_bytes.insert(file_bytes.size(), t);
    endtask

    task automatic put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            put_byte(v[8*i +: 8], 1'b0);
    endtask

    task automatic put_filler(input int n);
        for (int i = 0; i < n; i++)
            put_byte(8'($urandom), 1'b0);
    endtask

    task automatic put_data(input int size);
        put_le(wcsp_pkg::TAG_DATA, 4);
        put_le(32'(size), 4);
        put_filler(size + (size % 2));
    endtask

    task automatic put_fmt(input logic [31:0] size, input logic [15:0] code,
                           input logic [15:0] chans, input logic [31:0] rate,
                           input logic [15:0] bits);
        put_le(wcsp_pkg::TAG_FMT, 4);
        put_le(size, 4);
        put_le({16'd0, code}, 2);
        put_le({16'd0, chans}, 2);
        put_le(rate, 4);
        put_filler(6);
        put_le({16'd0, bits}, 2);
        put_filler((size > 32'd16 ? int'(size) - 16 : 0) + int'(size[0]));
    endtask

    task automatic write_rate(input logic [31:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        rate_cfg = v;
    endtask

    task automatic wait_drained();
        while (file_bytes.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on result %0d: %s got %0h, expected %0h",
                 checked, field, got, want);
        mismatches++;
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.insert(expected_results.size(), parse_byte(s_item));
                accepted++;
            end
            if (!s_valid || s_ready) begin
                if (file_bytes.size() != 0 &&
                    ((accepted >= CALM_FROM && accepted < CALM_TO) ||
                     $urandom_range(0, 99) >= 16)) begin
                    s_valid <= 1'b1;
                    s_item  <= file_bytes.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with one long hold-off to back up the input
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                taken++;
            if (taken == HOLD_AT && !held) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (taken >= CALM_FROM && taken < CALM_TO) ||
                           $urandom_range(0, 99) >= 16;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        wcsp_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending", 32'd0, 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (m_item.payload_byte != want.payload_byte)
                    report_mismatch("payload_byte", 32'(m_item.payload_byte),
                                    32'(want.payload_byte));
                if (m_item.payload_valid != want.payload_valid)
                    report_mismatch("payload_valid", 32'(m_item.payload_valid),
                                    32'(want.payload_valid));
                if (m_item.payload_first != want.payload_first)
                    report_mismatch("payload_first", 32'(m_item.payload_first),
                                    32'(want.payload_first));
                if (m_item.parse_status != want.parse_status)
                    report_mismatch("parse_status", 32'(m_item.parse_status),
                                    32'(want.parse_status));
                if (m_item.wave_format != want.wave_format)
                    report_mismatch("wave_format", 32'(m_item.wave_format),
                                    32'(want.wave_format));
                if (m_item.channel_count != want.channel_count)
                    report_mismatch("channel_count", 32'(m_item.channel_count),
                                    32'(want.channel_count));
                if (m_item.file_sample_rate != want.file_sample_rate)
                    report_mismatch("file_sample_rate", m_item.file_sample_rate,
                                    want.file_sample_rate);
                if (m_item.sample_bits != want.sample_bits)
                    report_mismatch("sample_bits", 32'(m_item.sample_bits),
                                    32'(want.sample_bits));
                if (m_item.rate_mismatch != want.rate_mismatch)
                    report_mismatch("rate_mismatch", 32'(m_item.rate_mismatch),
                                    32'(want.rate_mismatch));
            end
            checked++;
        end
    end

    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [31:0]   file_rate;
        logic [31:0]   rate_set[5];
        logic [31:0]   cid;
        logic [31:0]   fsz;
        logic [31:0]   fin_size;
        logic [15:0]   fc;
        logic [15:0]   fin_code;
        logic [15:0]   fin_chans;
        logic [15:0]   fin_bits;
        logic [15:0]   bits;
        logic          g_fmt;
        logic          g_data;
        int            sz;
        int            end_kind;
        wcsp_pkg::in_t t;

        cur_phase   = PH_RIFF_TAG;
        bytes_to_go = 33'd4;
        shift_word  = '0;
        chunk_kind  = CHUNK_OTHER;
        chunk_len   = '0;
        fmt_code    = '0;
        chan_count  = '0;
        rate_seen   = '0;
        bits_seen   = '0;
        have_data   = 1'b0;
        status_now  = wcsp_pkg::STATUS_BUSY;
        rate_cfg    = wcsp_pkg::EXPECTED_RATE_RESET;

        case ($urandom_range(0, 4))
            0: file_rate = 32'd48000;
            1: file_rate = 32'd44100;
            2: file_rate = 32'd0;
            3: file_rate = 32'hFFFF_FFFF;
            default: file_rate = $urandom;
        endcase

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        case ($urandom_range(0, 2))
            0: write_rate(file_rate);
            1: write_rate(32'd0);
            default: write_rate(32'hFFFF_FFFF);
        endcase

        // header, then payload ahead of any format
        put_le(wcsp_pkg::TAG_RIFF, 4);
        put_le($urandom, 4);
        put_le(wcsp_pkg::TAG_WAVE, 4);
        put_data(3);
        g_fmt  = 1'b0;
        g_data = 1'b1;

        // never let a held format and nonempty data coexist until the closing chunks
        while (file_bytes.size() < BODY_BYTES) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    sz = (g_fmt || $urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 24);
                    put_data(sz);
                    g_data = sz != 0;
                end
                3, 4, 5: begin
                    case ($urandom_range(0, 5))
                        0: fsz = 32'd0;
                        1: fsz = 32'd5;
                        2: fsz = 32'd17;
                        3: fsz = 32'($urandom_range(18, 30));
                        default: fsz = 32'd16;
                    endcase
                    if (g_data || $urandom_range(0, 1) == 0) begin
                        fc = 16'd0;
                    end else begin
                        case ($urandom_range(0, 2))
                            0: fc = wcsp_pkg::FORMAT_PCM;
                            1: fc = wcsp_pkg::FORMAT_FLOAT;
                            default: fc = 16'($urandom);
                        endcase
                    end
                    case ($urandom_range(0, 2))
                        0: bits = wcsp_pkg::BITS_PCM;
                        1: bits = wcsp_pkg::BITS_FLOAT;
                        default: bits = 16'(edgy(16));
                    endcase
                    put_fmt(fsz, fc, 16'(edgy(16)), edgy(32), bits);
                    g_fmt = fc != 16'd0;
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: cid = wcsp_pkg::TAG_FMT ^ (32'd1 << $urandom_range(0, 31));
                        1: cid = wcsp_pkg::TAG_DATA ^ (32'd1 << $urandom_range(0, 31));
                        2: cid = $urandom_range(0, 1) ? wcsp_pkg::TAG_RIFF
                                                      : wcsp_pkg::TAG_WAVE;
                        default: cid = $urandom;
                    endcase
                    if (cid == wcsp_pkg::TAG_FMT || cid == wcsp_pkg::TAG_DATA)
                        cid ^= 32'd1;
                    sz = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 30);
                    put_le(cid, 4);
                    put_le(32'(sz), 4);
                    put_filler(sz + (sz % 2));
                end
            endcase
        end

        end_kind = $urandom_range(0, 9);
        if (end_kind < 8) begin
            if (end_kind < 6) begin
                if ($urandom_range(0, 1)) begin
                    fin_code = wcsp_pkg::FORMAT_PCM;
                    fin_bits = wcsp_pkg::BITS_PCM;
                end else begin
                    fin_code = wcsp_pkg::FORMAT_FLOAT;
                    fin_bits = wcsp_pkg::BITS_FLOAT;
                end
                fin_chans = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 8));
            end else begin
                fin_chans = 16'd2;
                case ($urandom_range(0, 3))
                    0: begin
                        fin_code = wcsp_pkg::FORMAT_PCM;
                        fin_bits = wcsp_pkg::BITS_FLOAT;
                    end
                    1: begin
                        fin_code = wcsp_pkg::FORMAT_FLOAT;
                        fin_bits = wcsp_pkg::BITS_PCM;
                    end
                    2: begin
                        fin_code  = wcsp_pkg::FORMAT_PCM;
                        fin_bits  = wcsp_pkg::BITS_PCM;
                        fin_chans = 16'd0;
                    end
                    default: begin
                        fin_code = 16'($urandom_range(2, 16'hFFFF));
                        fin_bits = 16'd24;
                    end
                endcase
            end
            fin_size = 32'($urandom_range(16, 19));
            if ($urandom_range(0, 1)) begin
                put_data(0);
                put_fmt(fin_size, fin_code, fin_chans, file_rate, fin_bits);
                put_data($urandom_range(1, 20));
            end else begin
                put_fmt(32'd16, 16'd0, 16'($urandom), $urandom, 16'($urandom));
                put_data($urandom_range(1, 20));
                put_fmt(fin_size, fin_code, fin_chans, file_rate, fin_bits);
            end
        end else begin
            t = file_bytes.pop_back();
            t.end_of_file = 1'b1;
            file_bytes.insert(file_bytes.size(), t);
        end
        for (int i = 0; i < 3; i++)
            put_byte(8'($urandom), 1'($urandom));
        wait_drained();

        // parsing is over: rate compare still follows the register
        rate_set[0] = 32'd0;
        rate_set[1] = 32'hFFFF_FFFF;
        rate_set[2] = file_rate;
        rate_set[3] = file_rate ^ 32'h8000_0000;
        rate_set[4] = 32'd48000;
        for (int i = 0; i < 5; i++) begin
            write_rate(rate_set[i]);
            for (int j = 0; j < 4; j++)
                put_byte(8'($urandom), 1'($urandom));
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
